### sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, codes and helpers for the double-ended queue core.
// ----------------------------------------------------------------------------
package deq_pkg;

	// Capacity and stored word width
	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Field widths fixed by the interface
	localparam int REQ_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ_ALL   = 3'd4;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	// Datapath commands
	localparam int CMD_W = 3;
	localparam logic [CMD_W-1:0] CMD_NONE       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DUMP_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_DUMP_NEXT  = 3'd6;

	typedef struct packed {
		logic [REQ_W-1:0]          req_type;
		logic signed [VALUE_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] out_value;
		logic [STATUS_W-1:0]       status;
		logic [COUNT_W-1:0]        item_count;
		logic                      last_of_run;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic [CMD_W-1:0] op;
	} deq_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;   // result register can take a new result this cycle
		logic empty;
		logic single;     // exactly one stored value
		logic dump_end;   // next read-all step emits the back value
	} deq_stat_t;

	// (a + b) mod DEPTH for a, b below DEPTH
	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
	                                              input logic [IDX_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (IDX_W + 1)'(DEPTH)) begin
			s = s - (IDX_W + 1)'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	// Keep the low DATA_WIDTH bits of a pushed value
	function automatic logic [DATA_WIDTH-1:0] to_store(input logic [VALUE_W-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[DATA_WIDTH-1:0];
	endfunction

	// Present a stored word on the result field
	function automatic logic [VALUE_W-1:0] to_value(input logic [DATA_WIDTH-1:0] d);
		logic [63:0] w;
		w = 64'(d);
		return w[VALUE_W-1:0];
	endfunction

	function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] c);
		logic [63:0] w;
		w = 64'(c);
		return w[COUNT_W-1:0];
	endfunction

endpackage

### sv/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of signed values held in a ring buffer.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   req       in         req_valid/req_stall   req_type, push_value
//   rsp       out        rsp_valid/rsp_stall   out_value, status, item_count,
//                                              last_of_run
//
// For a pop, the storage read lands directly in the result register at
// the transfer edge. Read-all makes one storage read per cycle while the
// result register is free, and the request side stalls until the back
// value has gone out.
// A full result register stalls the request side until it is taken.
// Reset clears the front pointer, fill count and result valid; storage
// contents are not cleared and are only read after being written.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  deq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output deq_pkg::rsp_t rsp
);
	import deq_pkg::*;

	deq_cmd_t  cmd;
	deq_stat_t stat;

	// Decode requests, step through read-all
	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req.req_type),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold storage, pointers and the result register
	deq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_value (req.push_value),
		.stat       (stat),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

### sv/deq_dp.sv
// ----------------------------------------------------------------------------
// deq_dp
// Ring buffer storage, front pointer, fill count and result register.
// ----------------------------------------------------------------------------
module deq_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  deq_pkg::deq_cmd_t           cmd,
	input  logic [deq_pkg::VALUE_W-1:0] push_value,
	output deq_pkg::deq_stat_t          stat,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output deq_pkg::rsp_t               rsp
);
	import deq_pkg::*;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_q;

	logic [IDX_W-1:0] front_q, front_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic [IDX_W-1:0] off_q, off_n;

	logic             vld_q;
	logic             use_mem_q;
	logic [STATUS_W-1:0] status_q;
	logic [COUNT_W-1:0]  item_count_q;
	logic             last_q;

	logic             we, re, load, use_mem, last;
	logic [IDX_W-1:0] waddr, raddr;
	logic [IDX_W-1:0] front_dec, cnt_lo, cnt_m1_lo;
	logic [CNT_W-1:0] cnt_m1;
	logic [STATUS_W-1:0] status;
	logic             full, empty;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : (front_q - IDX_W'(1));
	assign cnt_m1    = count_q - CNT_W'(1);
	assign cnt_lo    = count_q[IDX_W-1:0];
	assign cnt_m1_lo = cnt_m1[IDX_W-1:0];
	assign load      = (cmd.op != CMD_NONE);

	assign stat.out_free = !vld_q || !rsp_stall;
	assign stat.empty    = empty;
	assign stat.single   = (count_q == CNT_W'(1));
	assign stat.dump_end = ((CNT_W'(off_q) + CNT_W'(1)) == count_q);

	always_comb begin
		we      = 1'b0;
		re      = 1'b0;
		use_mem = 1'b0;
		last    = 1'b1;
		waddr   = front_q;
		raddr   = front_q;
		front_n = front_q;
		count_n = count_q;
		off_n   = off_q;
		status  = STAT_OK;
		case (cmd.op)
			CMD_PUSH_FRONT: begin
				if (full) begin
					status = STAT_FULL;
				end else begin
					we      = 1'b1;
					waddr   = front_dec;
					front_n = front_dec;
					count_n = count_q + CNT_W'(1);
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					status = STAT_FULL;
				end else begin
					we      = 1'b1;
					waddr   = ring_add(front_q, cnt_lo);
					count_n = count_q + CNT_W'(1);
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					status = STAT_EMPTY;
				end else begin
					re      = 1'b1;
					use_mem = 1'b1;
					raddr   = front_q;
					front_n = ring_add(front_q, IDX_W'(1));
					count_n = cnt_m1;
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					status = STAT_EMPTY;
				end else begin
					re      = 1'b1;
					use_mem = 1'b1;
					raddr   = ring_add(front_q, cnt_m1_lo);
					count_n = cnt_m1;
				end
			end
			CMD_DUMP_FIRST: begin
				if (empty) begin
					status = STAT_EMPTY;
				end else begin
					re      = 1'b1;
					use_mem = 1'b1;
					raddr   = front_q;
					off_n   = IDX_W'(1);
					last    = (count_q == CNT_W'(1));
				end
			end
			CMD_DUMP_NEXT: begin
				re      = 1'b1;
				use_mem = 1'b1;
				raddr   = ring_add(front_q, off_q);
				off_n   = off_q + IDX_W'(1);
				last    = stat.dump_end;
			end
			default: begin
			end
		endcase
	end

	// Storage: write on push, registered read on pop and read-all
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= to_store(push_value);
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			off_q   <= '0;
			vld_q   <= 1'b0;
		end else begin
			front_q <= front_n;
			count_q <= count_n;
			off_q   <= off_n;
			if (load) begin
				vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			use_mem_q    <= use_mem;
			status_q     <= status;
			item_count_q <= to_count(count_n);
			last_q       <= last;
		end
	end

	assign rsp_valid        = vld_q;
	assign rsp.out_value    = use_mem_q ? to_value(rd_q) : '0;
	assign rsp.status       = status_q;
	assign rsp.item_count   = item_count_q;
	assign rsp.last_of_run  = last_q;

endmodule

### sv/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Request decode and read-all sequencing for the double-ended queue.
// ----------------------------------------------------------------------------
module deq_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [deq_pkg::REQ_W-1:0] req_type,
	input  deq_pkg::deq_stat_t       stat,
	output deq_pkg::deq_cmd_t        cmd
);
	import deq_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_DUMP = 1'b1;

	logic state_q, state_n;
	logic take;

	assign req_stall = !((state_q == S_IDLE) && stat.out_free);
	assign take      = req_valid && !req_stall;

	always_comb begin
		state_n = state_q;
		cmd.op  = CMD_NONE;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					case (req_type)
						REQ_PUSH_FRONT: cmd.op = CMD_PUSH_FRONT;
						REQ_PUSH_BACK:  cmd.op = CMD_PUSH_BACK;
						REQ_POP_FRONT:  cmd.op = CMD_POP_FRONT;
						REQ_POP_BACK:   cmd.op = CMD_POP_BACK;
						REQ_READ_ALL: begin
							cmd.op = CMD_DUMP_FIRST;
							if (!stat.empty && !stat.single) begin
								state_n = S_DUMP;
							end
						end
						default: cmd.op = CMD_NONE;
					endcase
				end
			end
			S_DUMP: begin
				if (stat.out_free) begin
					cmd.op = CMD_DUMP_NEXT;
					if (stat.dump_end) begin
						state_n = S_IDLE;
					end
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule
